>>> src/sfe_pkg.sv
// Shared types, codes and state conversion functions for the sensor fault escalation block.
package sfe_pkg;

    // Commands carried by an input item.
    typedef enum logic [1:0] {
        CMD_NOTE          = 2'd0,
        CMD_TICK          = 2'd1,
        CMD_RECOVERY_DONE = 2'd2,
        CMD_SET_STATE     = 2'd3
    } cmd_t;

    // Health codes reported by the sensor driver.
    localparam logic [2:0] HC_OK         = 3'd0;
    localparam logic [2:0] HC_CALIB_FAIL = 3'd1;
    localparam logic [2:0] HC_STUCK_IRQ  = 3'd2;
    localparam logic [2:0] HC_NACK       = 3'd3;
    localparam logic [2:0] HC_BUS_ERROR  = 3'd4;

    // External state encoding, as seen on the state field.
    localparam logic [2:0] SC_BOOT        = 3'd0;
    localparam logic [2:0] SC_CALIBRATING = 3'd1;
    localparam logic [2:0] SC_READY       = 3'd2;
    localparam logic [2:0] SC_CAPTURE     = 3'd3;
    localparam logic [2:0] SC_RECOVERING  = 3'd4;
    localparam logic [2:0] SC_FAULT_CAL   = 3'd5;
    localparam logic [2:0] SC_FAULT_STK   = 3'd6;
    localparam logic [2:0] SC_FAULT_NACK  = 3'd7;

    // Configuration register indexes.
    localparam logic CFG_RETRY_LIMIT  = 1'b0;
    localparam logic CFG_RETRY_PERIOD = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RETRY_LIMIT_RST  = 8'd3;
    localparam logic [31:0] RETRY_PERIOD_RST = 32'd1000;

    // Internal one-hot health state.
    typedef enum logic [7:0] {
        ST_BOOT        = 8'b0000_0001,
        ST_CALIBRATING = 8'b0000_0010,
        ST_READY       = 8'b0000_0100,
        ST_CAPTURE     = 8'b0000_1000,
        ST_RECOVERING  = 8'b0001_0000,
        ST_FAULT_CAL   = 8'b0010_0000,
        ST_FAULT_STK   = 8'b0100_0000,
        ST_FAULT_NACK  = 8'b1000_0000
    } state_t;

    // Decode an external state code into the one-hot state.
    function automatic state_t state_from_code(input logic [2:0] code);
        state_t s;
        unique case (code)
            SC_BOOT:        s = ST_BOOT;
            SC_CALIBRATING: s = ST_CALIBRATING;
            SC_READY:       s = ST_READY;
            SC_CAPTURE:     s = ST_CAPTURE;
            SC_RECOVERING:  s = ST_RECOVERING;
            SC_FAULT_CAL:   s = ST_FAULT_CAL;
            SC_FAULT_STK:   s = ST_FAULT_STK;
            SC_FAULT_NACK:  s = ST_FAULT_NACK;
            default:        s = ST_BOOT;
        endcase
        return s;
    endfunction

    // Encode the one-hot state into its external code.
    function automatic logic [2:0] state_to_code(input state_t s);
        logic [2:0] code;
        unique case (s)
            ST_BOOT:        code = SC_BOOT;
            ST_CALIBRATING: code = SC_CALIBRATING;
            ST_READY:       code = SC_READY;
            ST_CAPTURE:     code = SC_CAPTURE;
            ST_RECOVERING:  code = SC_RECOVERING;
            ST_FAULT_CAL:   code = SC_FAULT_CAL;
            ST_FAULT_STK:   code = SC_FAULT_STK;
            ST_FAULT_NACK:  code = SC_FAULT_NACK;
            default:        code = SC_BOOT;
        endcase
        return code;
    endfunction

endpackage

>>> src/sfe_in_if.sv
// Input channel carrying one command item per handshake.
interface sfe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [2:0]  health_code;
    logic [63:0] now_ms;
    logic [2:0]  new_state;

    modport source (output valid, command, health_code, now_ms, new_state, input ready);
    modport sink   (input valid, command, health_code, now_ms, new_state, output ready);
endinterface

>>> src/sfe_out_if.sv
// Output channel carrying one status item per handshake.
interface sfe_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] state;
    logic       in_fault;
    logic       recovery_request;
    logic [7:0] fail_count;

    modport source (output valid, state, in_fault, recovery_request, fail_count, input ready);
    modport sink   (input valid, state, in_fault, recovery_request, fail_count, output ready);
endinterface

>>> src/sensor_fault_escalation_fsm.sv
// Sensor health monitor: fault escalation state machine with paced recovery requests.
//
//  Channel     Direction  Handshake      Contents
//  item_in     sink       valid/ready    command, health_code, now_ms, new_state
//  result_out  source     valid/ready    state, in_fault, recovery_request, fail_count
//  cfg         write      cfg_we         cfg_index selects retry_limit or retry_period_ms
//
// Each item is captured in an input register; from there the state update and the status
// item are computed in a single pass and written to the state and result registers. One
// item is taken every cycle while the result side is not stalled; the path is set by
// the 64-bit deadline subtract and add. Reset puts the monitor in boot with a zero count
// and deadline. A stalled result holds its register while the input register can still
// take one more item; the input side stalls only when both are full.
module sensor_fault_escalation_fsm (
    input  logic        clk,
    input  logic        rst_n,
    sfe_in_if.sink      item_in,
    sfe_out_if.source   result_out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    // Input register stage.
    logic        s1_valid_reg;
    logic [1:0]  cmd_reg;
    logic [2:0]  code_reg;
    logic [63:0] now_reg;
    logic [2:0]  new_state_reg;

    // Monitor state and configuration.
    sfe_pkg::state_t state_reg, state_next;
    logic [7:0]  err_reg, err_next;
    logic [63:0] deadline_reg, deadline_next;
    logic [7:0]  limit_reg;
    logic [31:0] period_reg;

    // Result register stage.
    logic        out_valid_reg;
    logic [2:0]  out_state_reg;
    logic        out_fault_reg;
    logic        out_req_reg;
    logic [7:0]  out_count_reg;

    logic        s2_ready;
    logic        s2_adv;
    logic        in_acc;
    logic        req_next;
    logic [7:0]  err_inc;
    logic [63:0] elapsed;
    logic        active;
    logic [2:0]  state_code_next;

    // Handshake control.
    assign s2_ready       = !out_valid_reg || result_out.ready;
    assign s2_adv         = s1_valid_reg && s2_ready;
    assign item_in.ready  = !s1_valid_reg || s2_ready;
    assign in_acc         = item_in.valid && item_in.ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s2_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg       <= item_in.command;
            code_reg      <= item_in.health_code;
            now_reg       <= item_in.now_ms;
            new_state_reg <= item_in.new_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= sfe_pkg::RETRY_LIMIT_RST;
            period_reg <= sfe_pkg::RETRY_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == sfe_pkg::CFG_RETRY_LIMIT)
            begin
                limit_reg <= cfg_wdata[7:0];
            end
            else
            begin
                period_reg <= cfg_wdata;
            end
        end
    end

    // Shared terms of the update.
    assign err_inc = (err_reg == 8'hFF) ? 8'hFF : err_reg + 8'd1;
    assign elapsed = now_reg - deadline_reg;
    assign active  = (state_reg == sfe_pkg::ST_RECOVERING)
                  || (state_reg == sfe_pkg::ST_FAULT_CAL)
                  || (state_reg == sfe_pkg::ST_FAULT_STK)
                  || (state_reg == sfe_pkg::ST_FAULT_NACK);

    // Next state for the item in the input register.
    always_comb
    begin
        state_next    = state_reg;
        err_next      = err_reg;
        deadline_next = deadline_reg;
        req_next      = 1'b0;
        unique case (sfe_pkg::cmd_t'(cmd_reg))
            sfe_pkg::CMD_NOTE:
            begin
                priority if (code_reg == sfe_pkg::HC_OK)
                begin
                    if (state_reg != sfe_pkg::ST_CAPTURE)
                    begin
                        state_next = sfe_pkg::ST_READY;
                    end
                    err_next = 8'd0;
                end
                else if (code_reg == sfe_pkg::HC_CALIB_FAIL)
                begin
                    state_next = sfe_pkg::ST_FAULT_CAL;
                end
                else if (code_reg == sfe_pkg::HC_STUCK_IRQ)
                begin
                    state_next = sfe_pkg::ST_FAULT_STK;
                end
                else
                begin
                    // Transient error: count it and escalate at the limit.
                    err_next = err_inc;
                    if (err_inc >= limit_reg)
                    begin
                        state_next = (code_reg == sfe_pkg::HC_BUS_ERROR)
                                   ? sfe_pkg::ST_FAULT_STK : sfe_pkg::ST_FAULT_NACK;
                    end
                    else if (state_reg == sfe_pkg::ST_READY || state_reg == sfe_pkg::ST_BOOT)
                    begin
                        state_next = sfe_pkg::ST_RECOVERING;
                    end
                end
            end
            sfe_pkg::CMD_TICK:
            begin
                // Start a recovery attempt once the deadline has been reached, in a recovering or fault state.
                if (active && !elapsed[63])
                begin
                    deadline_next = now_reg + {32'd0, period_reg};
                    state_next    = sfe_pkg::ST_RECOVERING;
                    req_next      = 1'b1;
                end
            end
            sfe_pkg::CMD_RECOVERY_DONE:
            begin
                priority if (code_reg == sfe_pkg::HC_OK)
                begin
                    state_next = sfe_pkg::ST_READY;
                    err_next   = 8'd0;
                end
                else if (code_reg == sfe_pkg::HC_CALIB_FAIL)
                begin
                    state_next = sfe_pkg::ST_FAULT_CAL;
                end
                else
                begin
                    state_next = sfe_pkg::ST_FAULT_NACK;
                end
            end
            sfe_pkg::CMD_SET_STATE:
            begin
                state_next = sfe_pkg::state_from_code(new_state_reg);
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    assign state_code_next = sfe_pkg::state_to_code(state_next);

    // Monitor state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sfe_pkg::ST_BOOT;
            err_reg      <= 8'd0;
            deadline_reg <= 64'd0;
        end
        else if (s2_adv)
        begin
            state_reg    <= state_next;
            err_reg      <= err_next;
            deadline_reg <= deadline_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_state_reg <= state_code_next;
            out_fault_reg <= (state_code_next >= sfe_pkg::SC_FAULT_CAL);
            out_req_reg   <= req_next;
            out_count_reg <= err_next;
        end
    end

    assign result_out.valid            = out_valid_reg;
    assign result_out.state            = out_state_reg;
    assign result_out.in_fault         = out_fault_reg;
    assign result_out.recovery_request = out_req_reg;
    assign result_out.fail_count       = out_count_reg;

    // A recovery request is only ever reported together with the recovering state.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.recovery_request
            |-> result_out.state == sfe_pkg::SC_RECOVERING)
        else $error("recovery request without recovering state");

    // The deadline moves only when a recovery attempt is started.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s2_adv && req_next) |=> $stable(deadline_reg))
        else $error("retry deadline changed without a recovery request");

    // An OK health note always clears the fail count.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_adv && cmd_reg == sfe_pkg::CMD_NOTE && code_reg == sfe_pkg::HC_OK
            |=> err_reg == 8'd0)
        else $error("OK note did not clear the fail count");

    // Ticks and state writes never touch the fail count.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_adv && (cmd_reg == sfe_pkg::CMD_TICK || cmd_reg == sfe_pkg::CMD_SET_STATE)
            |=> $stable(err_reg))
        else $error("fail count changed by tick or set-state");

endmodule
